/* hw/rtl/cbmf_pkg.sv */
// Shared constants for the clipped box mean filter core.
// No dependencies; used by clipped_box_mean_filter_core.
`default_nettype none

package cbmf_pkg;

  // input item kinds
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // field widths
  localparam int SAMPLE_W  = 8;
  localparam int OUT_W     = 16;
  localparam int FRAC_BITS = 8;
  localparam int CFG_W_W   = 11;
  localparam int CFG_H_W   = 13;
  localparam int CFG_R_W   = 3;
  localparam int APB_A_W   = 4;
  localparam int APB_D_W   = 32;

endpackage

`default_nettype wire

/* hw/rtl/clipped_box_mean_filter_core.sv */
// Top level of the clipped box mean filter: line store, window walk, control.
// Depends on cbmf_pkg and cbmf_div.
`default_nettype none

//  channel  | ports                              | direction
//  ---------+------------------------------------+-----------
//  input    | in_valid/in_ready, in_opcode,      | in
//           | in_sample                          |
//  result   | out_valid/out_ready,               | out
//           | out_smoothed_height, out_frame_last|
//  config   | psel/penable/pwrite/paddr/pwdata,  | in/out
//           | prdata, pready                     |
//
// An item with a result walks the n samples in the clipped window and
// divides their sum: the line store has one read port, walked one sample
// per cycle, and the divider retires one quotient bit per cycle. Reset is
// synchronous and needs no clearing pass. A finished result waits in the
// output register while the next item is taken; the block stalls only when a
// second one is ready.

module clipped_box_mean_filter_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_opcode,
  input  wire logic [cbmf_pkg::SAMPLE_W-1:0] in_sample,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [cbmf_pkg::OUT_W-1:0]         out_smoothed_height,
  output logic                               out_frame_last,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cbmf_pkg::APB_A_W-1:0]  paddr,
  input  wire logic [cbmf_pkg::APB_D_W-1:0]  pwdata,
  output logic [cbmf_pkg::APB_D_W-1:0]       prdata,
  output logic                               pready
);

  localparam int DEPTH  = (2 * MAX_RADIUS + 1) * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WU_W   = $clog2(MAX_WIDTH + 1);
  localparam int HU_W   = $clog2(MAX_HEIGHT + 1);
  localparam int RU_W   = $clog2(MAX_RADIUS + 2);
  localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_RADIUS * MAX_WIDTH
                                 + MAX_RADIUS + 2);
  localparam int WIN    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CNT_W  = $clog2(WIN + 1);
  localparam int SUM_W  = $clog2(255 * WIN + 1);
  localparam int NUM_W  = SUM_W + cbmf_pkg::FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EVAL, ST_BOUND, ST_BASE, ST_ADDR,
    ST_READ, ST_TAIL, ST_DIV, ST_WAIT, ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [cbmf_pkg::CFG_W_W-1:0] cfg_width_r, cfg_width_nxt;
  logic [cbmf_pkg::CFG_H_W-1:0] cfg_height_r, cfg_height_nxt;
  logic [cbmf_pkg::CFG_R_W-1:0] cfg_radius_r, cfg_radius_nxt;

  // frame geometry, clamped
  logic [31:0]     w_cl, h_cl, r_cl;
  logic [WU_W-1:0] w_use;
  logic [HU_W-1:0] h_use;
  logic [RU_W-1:0] r_use;
  logic [POS_W-1:0] total_r, lag_r;

  // frame positions
  logic [POS_W-1:0]  in_pos_r, in_pos_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [POS_W-1:0]  nwr_r, nwr_nxt;
  logic [WU_W-1:0]   out_x_r, out_x_nxt;
  logic [HU_W-1:0]   out_y_r, out_y_nxt;
  logic [ADDR_W-1:0] wptr_r, wptr_nxt;

  // latched item
  logic                          op_r, op_nxt;
  logic [cbmf_pkg::SAMPLE_W-1:0] sample_r, sample_nxt;

  // window walk
  logic [WU_W-1:0]   x0_r, x0_nxt, x1_r, x1_nxt, xx_r, xx_nxt;
  logic [HU_W-1:0]   y0_r, y0_nxt, y1_r, y1_nxt, yy_r, yy_nxt;
  logic [POS_W-1:0]  p0_r, p0_nxt;
  logic [ADDR_W-1:0] row_addr_r, row_addr_nxt;
  logic [ADDR_W-1:0] rd_addr_r, rd_addr_nxt;
  logic              acc_en_r, acc_en_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic [cbmf_pkg::OUT_W-1:0] out_height_r, out_height_nxt;
  logic                       out_last_r, out_last_nxt;

  // line store
  logic [cbmf_pkg::SAMPLE_W-1:0] store_mem [DEPTH];
  logic [cbmf_pkg::SAMPLE_W-1:0] rd_data_r;
  logic                          mem_we;

  // divider hookup
  logic             div_start;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  // scratch
  logic [31:0]       ox, oy, rr, ww, hh;
  logic [31:0]       x0_c, x1_c, y0_c, y1_c;
  logic [POS_W-1:0]  d0;
  logic [ADDR_W-1:0] d0a;
  logic [ADDR_W:0]   wrap_tmp;
  logic [ADDR_W:0]   row_tmp;
  logic              cfg_we;
  logic [1:0]        cfg_idx;

  // clamp the registers to the supported range
  always_comb begin
    if (cfg_width_r == '0) w_cl = 32'd1;
    else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) w_cl = 32'(MAX_WIDTH);
    else w_cl = 32'(cfg_width_r);
    if (cfg_height_r == '0) h_cl = 32'd1;
    else if (32'(cfg_height_r) > 32'(MAX_HEIGHT)) h_cl = 32'(MAX_HEIGHT);
    else h_cl = 32'(cfg_height_r);
    if (32'(cfg_radius_r) > 32'(MAX_RADIUS)) r_cl = 32'(MAX_RADIUS);
    else r_cl = 32'(cfg_radius_r);
    w_use = w_cl[WU_W-1:0];
    h_use = h_cl[HU_W-1:0];
    r_use = r_cl[RU_W-1:0];
  end

  // register read mux
  assign cfg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;

  always_comb begin
    unique case (cfg_idx)
      cbmf_pkg::REG_WIDTH:  prdata = 32'(cfg_width_r);
      cbmf_pkg::REG_HEIGHT: prdata = 32'(cfg_height_r);
      cbmf_pkg::REG_RADIUS: prdata = 32'(cfg_radius_r);
      default:              prdata = '0;
    endcase
  end

  // window bounds from the current result coordinate
  always_comb begin
    ox = 32'(out_x_r);
    oy = 32'(out_y_r);
    rr = 32'(r_use);
    ww = 32'(w_use);
    hh = 32'(h_use);
    x0_c = (ox >= rr) ? ox - rr : 32'd0;
    y0_c = (oy >= rr) ? oy - rr : 32'd0;
    x1_c = (ox + rr >= ww) ? ww - 32'd1 : ox + rr;
    y1_c = (oy + rr >= hh) ? hh - 32'd1 : oy + rr;
  end

  // first window address, relative to the write pointer
  always_comb begin
    d0       = nwr_r - p0_r;
    d0a      = d0[ADDR_W-1:0];
    wrap_tmp = {1'b0, wptr_r} + (ADDR_W+1)'(DEPTH) - {1'b0, d0a};
    row_tmp  = {1'b0, row_addr_r} + (ADDR_W+1)'(w_use);
    if (row_tmp >= (ADDR_W+1)'(DEPTH)) row_tmp = row_tmp - (ADDR_W+1)'(DEPTH);
  end

  // control and datapath
  always_comb begin
    state_nxt      = state_r;
    cfg_width_nxt  = cfg_width_r;
    cfg_height_nxt = cfg_height_r;
    cfg_radius_nxt = cfg_radius_r;
    in_pos_nxt     = in_pos_r;
    out_pos_nxt    = out_pos_r;
    nwr_nxt        = nwr_r;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    wptr_nxt       = wptr_r;
    op_nxt         = op_r;
    sample_nxt     = sample_r;
    x0_nxt         = x0_r;
    x1_nxt         = x1_r;
    xx_nxt         = xx_r;
    y0_nxt         = y0_r;
    y1_nxt         = y1_r;
    yy_nxt         = yy_r;
    p0_nxt         = p0_r;
    row_addr_nxt   = row_addr_r;
    rd_addr_nxt    = rd_addr_r;
    acc_en_nxt     = 1'b0;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_height_nxt = out_height_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    div_start      = 1'b0;

    // result taken downstream
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    // accumulate the sample read last cycle
    if (acc_en_r) sum_nxt = sum_r + SUM_W'(rd_data_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_opcode;
          sample_nxt = in_sample;
          state_nxt  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_IDLE;
        if (in_pos_r < total_r && op_r == cbmf_pkg::OP_DRAIN) begin
          // early drain, ignored
        end else begin
          if (in_pos_r < total_r) begin
            mem_we   = 1'b1;
            wptr_nxt = (wptr_r == ADDR_W'(DEPTH - 1)) ? '0 : wptr_r + ADDR_W'(1);
            nwr_nxt  = in_pos_r + POS_W'(1);
          end else begin
            nwr_nxt  = total_r;
          end
          in_pos_nxt = in_pos_r + POS_W'(1);
          if (in_pos_r + POS_W'(1) >= out_pos_r + lag_r + POS_W'(1)
              && out_pos_r < total_r) begin
            state_nxt = ST_BOUND;
          end
        end
      end
      ST_BOUND: begin
        x0_nxt    = x0_c[WU_W-1:0];
        x1_nxt    = x1_c[WU_W-1:0];
        y0_nxt    = y0_c[HU_W-1:0];
        y1_nxt    = y1_c[HU_W-1:0];
        state_nxt = ST_BASE;
      end
      ST_BASE: begin
        p0_nxt    = POS_W'(y0_r) * POS_W'(w_use) + POS_W'(x0_r);
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        if (wptr_r >= d0a) rd_addr_nxt = wptr_r - d0a;
        else rd_addr_nxt = wrap_tmp[ADDR_W-1:0];
        row_addr_nxt = rd_addr_nxt;
        xx_nxt       = x0_r;
        yy_nxt       = y0_r;
        sum_nxt      = '0;
        cnt_nxt      = '0;
        state_nxt    = ST_READ;
      end
      ST_READ: begin
        // one store read per cycle
        acc_en_nxt = 1'b1;
        cnt_nxt    = cnt_r + CNT_W'(1);
        if (xx_r == x1_r) begin
          if (yy_r == y1_r) begin
            state_nxt = ST_TAIL;
          end else begin
            yy_nxt       = yy_r + HU_W'(1);
            xx_nxt       = x0_r;
            row_addr_nxt = row_tmp[ADDR_W-1:0];
            rd_addr_nxt  = row_tmp[ADDR_W-1:0];
          end
        end else begin
          xx_nxt      = xx_r + WU_W'(1);
          rd_addr_nxt = (rd_addr_r == ADDR_W'(DEPTH - 1)) ? '0 : rd_addr_r + ADDR_W'(1);
        end
      end
      ST_TAIL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_height_nxt = div_quo[cbmf_pkg::OUT_W-1:0];
          out_last_nxt   = (out_pos_r + POS_W'(1) == total_r);
          state_nxt      = ST_IDLE;
          if (out_pos_r + POS_W'(1) == total_r) begin
            // frame done, start over
            in_pos_nxt  = '0;
            out_pos_nxt = '0;
            out_x_nxt   = '0;
            out_y_nxt   = '0;
            wptr_nxt    = '0;
          end else begin
            out_pos_nxt = out_pos_r + POS_W'(1);
            if (32'(out_x_r) + 32'd1 == 32'(w_use)) begin
              out_x_nxt = '0;
              out_y_nxt = out_y_r + HU_W'(1);
            end else begin
              out_x_nxt = out_x_r + WU_W'(1);
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // register write, other than to the unused index, restarts the frame
    if (cfg_we) begin
      unique case (cfg_idx)
        cbmf_pkg::REG_WIDTH: begin
          cfg_width_nxt = pwdata[cbmf_pkg::CFG_W_W-1:0];
        end
        cbmf_pkg::REG_HEIGHT: begin
          cfg_height_nxt = pwdata[cbmf_pkg::CFG_H_W-1:0];
        end
        cbmf_pkg::REG_RADIUS: begin
          cfg_radius_nxt = pwdata[cbmf_pkg::CFG_R_W-1:0];
        end
        default: ;
      endcase
      if (cfg_idx != cbmf_pkg::REG_UNUSED) begin
        in_pos_nxt  = '0;
        out_pos_nxt = '0;
        out_x_nxt   = '0;
        out_y_nxt   = '0;
        wptr_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_width_r  <= cbmf_pkg::CFG_W_W'(1024);
      cfg_height_r <= cbmf_pkg::CFG_H_W'(1024);
      cfg_radius_r <= cbmf_pkg::CFG_R_W'(1);
      in_pos_r     <= '0;
      out_pos_r    <= '0;
      out_x_r      <= '0;
      out_y_r      <= '0;
      wptr_r       <= '0;
      acc_en_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cfg_width_r  <= cfg_width_nxt;
      cfg_height_r <= cfg_height_nxt;
      cfg_radius_r <= cfg_radius_nxt;
      in_pos_r     <= in_pos_nxt;
      out_pos_r    <= out_pos_nxt;
      out_x_r      <= out_x_nxt;
      out_y_r      <= out_y_nxt;
      wptr_r       <= wptr_nxt;
      acc_en_r     <= acc_en_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    total_r      <= POS_W'(w_use) * POS_W'(h_use);
    lag_r        <= POS_W'(r_use) * POS_W'(w_use) + POS_W'(r_use);
    nwr_r        <= nwr_nxt;
    op_r         <= op_nxt;
    sample_r     <= sample_nxt;
    x0_r         <= x0_nxt;
    x1_r         <= x1_nxt;
    xx_r         <= xx_nxt;
    y0_r         <= y0_nxt;
    y1_r         <= y1_nxt;
    yy_r         <= yy_nxt;
    p0_r         <= p0_nxt;
    row_addr_r   <= row_addr_nxt;
    rd_addr_r    <= rd_addr_nxt;
    sum_r        <= sum_nxt;
    cnt_r        <= cnt_nxt;
    out_height_r <= out_height_nxt;
    out_last_r   <= out_last_nxt;
  end

  // line store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) store_mem[wptr_r] <= sample_r;
    rd_data_r <= store_mem[rd_addr_r];
  end

  // mean = (sum << 8) / count
  cbmf_div #(
    .NUM_W(NUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  ({sum_r, {cbmf_pkg::FRAC_BITS{1'b0}}}),
    .den  (cnt_r),
    .done (div_done),
    .quo  (div_quo)
  );

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_smoothed_height = out_height_r;
  assign out_frame_last      = out_last_r;

endmodule

`default_nettype wire

/* hw/rtl/cbmf_div.sv */
// Restoring divider, one quotient bit per cycle.
// Stand-alone; used by clipped_box_mean_filter_core.
`default_nettype none

module cbmf_div #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  // one shift-subtract step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    trial    = {rem_r, num_r[NUM_W-1]};
    diff     = trial - {1'b0, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      num_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

`default_nettype wire
